### hw/rtl/macs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package macs_pkg;

  // Width of the physical word address that takes part in the address word.
  localparam int unsigned AddressBits = 23;
  localparam logic [22:0] AddrMask    = 23'((64'd1 << AddressBits) - 64'd1);
  // Address bits that form the high parity group.
  localparam logic [22:0] HighGroup   = AddrMask & ~23'h3ff;

  // Request operation codes.
  typedef enum logic [1:0] {
    OpStore  = 2'd0,
    OpLoad   = 2'd1,
    OpReset  = 2'd2,
    OpUnused = 2'd3
  } op_e;

  // Target register codes.
  localparam logic [7:0] RegAddr    = 8'd252;
  localparam logic [7:0] RegWrWord  = 8'd254;
  localparam logic [7:0] RegTrigger = 8'd235;
  localparam logic [7:0] RegButton1 = 8'd233;

  // Command values for the fixed commands.
  localparam logic [7:0] TriggerCmd = 8'd1;
  localparam logic [7:0] ButtonCmd  = 8'd3;

  // Sequencer steps within one request.
  typedef logic [3:0] step_t;
  localparam step_t StepAddr0  = 4'd0;
  localparam step_t StepAddr3  = 4'd3;
  localparam step_t StepTag    = 4'd4;
  localparam step_t StepLeft0  = 4'd5;
  localparam step_t StepLeft3  = 4'd8;
  localparam step_t StepRight0 = 4'd9;
  localparam step_t StepRight3 = 4'd12;
  localparam step_t StepTrig   = 4'd13;
  localparam step_t StepButton = 4'd15;

  // One command on the result channel.
  typedef struct packed {
    logic [7:0] command_value;
    logic [7:0] target_register;
    logic       direct_command;
    logic       last_of_run;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/macs_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface macs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [22:0] mem_address;
  logic [31:0] left_word;
  logic [31:0] right_word;

  modport source (output valid, operation, mem_address, left_word, right_word,
                  input ready);
  modport sink (input valid, operation, mem_address, left_word, right_word,
                output ready);
endinterface

`default_nettype wire

### hw/rtl/macs_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface macs_cmd_if;
  logic       valid;
  logic       ready;
  logic [7:0] command_value;
  logic [7:0] target_register;
  logic       direct_command;
  logic       last_of_run;

  modport source (output valid, command_value, target_register, direct_command,
                  last_of_run, input ready);
  modport sink (input valid, command_value, target_register, direct_command,
                last_of_run, output ready);
endinterface

`default_nettype wire

### hw/rtl/memory_access_command_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

// Memory access command serializer.
//
// req_i takes one request per transfer: store word, load word or processor
// reset. cmd_o gives the console commands for it, one command per transfer,
// with last_of_run set on the final command of each request.
// An accepted request is held in a work register; a sequencer step counter
// walks it and loads one command per cycle, while the receiver does not
// stall, into the output register, which gives the first command. Per
// request the step counter sets 14 commands for a store with an address
// word, 10 without, 5 or 1 for a load, 1 for a reset. The next request is
// taken in the same cycle as the last command of the current one is formed,
// so requests follow each other without a gap. Operation code 3 is accepted
// and produces nothing. Reset clears the address cache and the valid flags
// of the work register and the output register, but not their payload.
// When the receiver stalls, the output register holds its command and the
// sequencer waits; the request side stalls once the work register is busy.
module memory_access_command_serializer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  macs_req_if.sink    req_i,
  macs_cmd_if.source  cmd_o
);
  import macs_pkg::*;

  // Request side.
  logic        req_acc;
  logic [22:0] addr;
  logic        is_store;
  logic [26:0] raw;
  logic        send_addr;
  logic        par_lo;
  logic        par_hi;
  step_t       start_step;

  // Work register.
  logic        work_valid_q, work_valid_d;
  logic        store_q;
  logic [31:0] addr_word_q;
  logic [31:0] left_q;
  logic [31:0] right_q;
  logic [1:0]  tag_q;
  step_t       step_q, step_d;

  // Address cache.
  logic        cache_valid_q;
  logic [26:0] cached_q;

  // Sequencer and output register.
  logic        gen;
  logic        is_last;
  cmd_t        cmd;
  logic        out_valid_q;
  cmd_t        out_q;

  function automatic logic [7:0] pick_byte(logic [31:0] w, logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  // Decode the incoming request and check the address cache.
  assign addr      = req_i.mem_address & AddrMask;
  assign is_store  = (op_e'(req_i.operation) == OpStore);
  assign raw       = {is_store, 3'b000, addr};
  assign send_addr = !(cache_valid_q && (raw == cached_q));
  assign par_lo    = ~^{is_store, addr[9:0]};
  assign par_hi    = ~^(addr & HighGroup);

  always_comb begin
    case (op_e'(req_i.operation))
      OpReset: start_step = StepButton;
      default: begin
        if (send_addr) begin
          start_step = StepAddr0;
        end else if (is_store) begin
          start_step = StepTag;
        end else begin
          start_step = StepTrig;
        end
      end
    endcase
  end

  // Form the command of the current step.
  always_comb begin
    cmd = '0;
    case (step_q) inside
      [StepAddr0:StepAddr3]: begin
        cmd.command_value   = pick_byte(addr_word_q, step_q[1:0]);
        cmd.target_register = RegAddr;
      end
      StepTag: begin
        cmd.command_value   = {1'b0, tag_q, 5'b00000};
        cmd.target_register = RegWrWord;
      end
      [StepLeft0:StepLeft3]: begin
        cmd.command_value   = pick_byte(left_q, 2'(step_q - StepLeft0));
        cmd.target_register = RegWrWord;
      end
      [StepRight0:StepRight3]: begin
        cmd.command_value   = pick_byte(right_q, 2'(step_q - StepRight0));
        cmd.target_register = RegWrWord;
      end
      StepTrig: begin
        cmd.command_value   = TriggerCmd;
        cmd.target_register = RegTrigger;
        cmd.direct_command  = 1'b1;
      end
      default: begin
        cmd.command_value   = ButtonCmd;
        cmd.target_register = RegButton1;
      end
    endcase
    cmd.last_of_run = is_last;
  end

  assign is_last = (step_q == StepTrig) || (step_q == StepButton);
  assign gen     = work_valid_q && (!out_valid_q || cmd_o.ready);
  assign req_i.ready = !work_valid_q || (gen && is_last);
  assign req_acc = req_i.valid && req_i.ready;

  // Next state of the work register.
  always_comb begin
    work_valid_d = work_valid_q;
    step_d       = step_q;
    if (gen) begin
      if (is_last) begin
        work_valid_d = 1'b0;
      end else if (step_q == StepAddr3 && !store_q) begin
        step_d = StepTrig;
      end else begin
        step_d = step_q + 4'd1;
      end
    end
    if (req_acc) begin
      work_valid_d = (op_e'(req_i.operation) != OpUnused);
      step_d       = start_step;
    end
  end

  // Work register control and address cache.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q  <= 1'b0;
      step_q        <= StepAddr0;
      cache_valid_q <= 1'b0;
      cached_q      <= '0;
    end else begin
      work_valid_q <= work_valid_d;
      step_q       <= step_d;
      if (req_acc) begin
        case (op_e'(req_i.operation))
          OpStore, OpLoad: begin
            cache_valid_q <= 1'b1;
            cached_q      <= raw;
          end
          OpReset: begin
            cache_valid_q <= 1'b0;
            cached_q      <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Work register payload.
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      store_q     <= is_store;
      addr_word_q <= {3'b000, par_hi, par_lo, is_store, 3'b000, addr};
      left_q      <= req_i.left_word;
      right_q     <= req_i.right_word;
      tag_q       <= {~^req_i.left_word, ~^req_i.right_word};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (gen) begin
      out_valid_q <= 1'b1;
    end else if (cmd_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen) begin
      out_q <= cmd;
    end
  end

  assign cmd_o.valid           = out_valid_q;
  assign cmd_o.command_value   = out_q.command_value;
  assign cmd_o.target_register = out_q.target_register;
  assign cmd_o.direct_command  = out_q.direct_command;
  assign cmd_o.last_of_run     = out_q.last_of_run;

  // A processor reset request invalidates the address cache.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && op_e'(req_i.operation) == OpReset) |=> !cache_valid_q)
    else $error("cache still valid after reset request");

  // A store or load leaves its raw address in the cache.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && (op_e'(req_i.operation) == OpStore || op_e'(req_i.operation) == OpLoad))
    |=> (cache_valid_q && cached_q == $past(raw)))
    else $error("cache not updated by request");

  // A command that is not the last keeps the request in the work register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen && !is_last) |=> work_valid_q)
    else $error("request dropped before its last command");

endmodule

`default_nettype wire

### test/tb_memory_access_command_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_memory_access_command_serializer;
  import macs_pkg::*;

  localparam int unsigned ClkHalf        = 5;
  localparam int unsigned RandomRequests = 135;
  localparam int unsigned IdleLimit      = 1000;
  localparam int unsigned DrainCycles    = 40;
  localparam int unsigned ReportLimit    = 10;

  // Address word layout: write flag and the low parity group mask.
  localparam logic [26:0] WriteBit = 27'h4000000;
  localparam logic [26:0] LowGroup = 27'h40003ff;

  // Commands that can be typed in directly.
  localparam cmd_t TrigOnly   = '{TriggerCmd, RegTrigger, 1'b1, 1'b1};
  localparam cmd_t ButtonOnly = '{ButtonCmd, RegButton1, 1'b0, 1'b1};
  localparam cmd_t NoCmd      = '0;

  // One request; typed rows carry their expected command, or none for the
  // unused operation code.
  typedef struct {
    op_e         op;
    logic [22:0] addr;
    logic [31:0] lw;
    logic [31:0] rw;
    bit          typed;
    cmd_t        tcmd;
  } request_t;

  logic clk;
  logic rst_n;

  macs_req_if req_if ();
  macs_cmd_if cmd_if ();

  memory_access_command_serializer u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .cmd_o (cmd_if)
  );

  // Address cache as seen from outside.
  logic [26:0] addr_cache;
  bit          addr_cache_ok;

  cmd_t run_cmds[$];
  cmd_t expected_cmds[$];
  int   mismatches;
  bit   no_gaps;
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  function automatic logic even_par(logic [31:0] w);
    return ~^w;
  endfunction

  function automatic void add_cmd(logic [7:0] value, logic [7:0] target, logic direct);
    cmd_t c;
    c.command_value   = value;
    c.target_register = target;
    c.direct_command  = direct;
    c.last_of_run     = 1'b0;
    run_cmds.push_back(c);
  endfunction

  // Four bytes, most significant first.
  function automatic void add_word(logic [31:0] w, logic [7:0] target);
    add_cmd(w[31:24], target, 1'b0);
    add_cmd(w[23:16], target, 1'b0);
    add_cmd(w[15:8], target, 1'b0);
    add_cmd(w[7:0], target, 1'b0);
  endfunction

  // The address word goes out only on a cache miss; parity bits are not cached.
  function automatic void add_address(logic [26:0] raw);
    logic [31:0] w;
    if (addr_cache_ok && raw == addr_cache) return;
    w = {3'b000, even_par(32'(raw[22:0] & HighGroup)), even_par(32'(raw & LowGroup)), raw};
    add_word(w, RegAddr);
    addr_cache    = raw;
    addr_cache_ok = 1'b1;
  endfunction

  // Works out the command run for one request and updates the cache copy.
  function automatic void forecast_commands(op_e op, logic [22:0] addr, logic [31:0] lw,
                                            logic [31:0] rw);
    logic [26:0] raw;
    run_cmds.delete();
    raw = 27'(addr & AddrMask);
    case (op)
      OpStore: begin
        add_address(raw | WriteBit);
        add_cmd({1'b0, even_par(lw), even_par(rw), 5'b0}, RegWrWord, 1'b0);
        add_word(lw, RegWrWord);
        add_word(rw, RegWrWord);
        add_cmd(TriggerCmd, RegTrigger, 1'b1);
      end
      OpLoad: begin
        add_address(raw);
        add_cmd(TriggerCmd, RegTrigger, 1'b1);
      end
      OpReset: begin
        add_cmd(ButtonCmd, RegButton1, 1'b0);
        addr_cache_ok = 1'b0;
        addr_cache    = '0;
      end
      default: ;
    endcase
    if (run_cmds.size() > 0) run_cmds[run_cmds.size() - 1].last_of_run = 1'b1;
  endfunction

  // Drives one request after a random gap and queues its commands on transfer.
  task automatic issue_request(request_t rq);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.operation   = rq.op;
    req_if.mem_address = rq.addr;
    req_if.left_word   = rq.lw;
    req_if.right_word  = rq.rw;
    req_if.valid       = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    forecast_commands(rq.op, rq.addr, rq.lw, rq.rw);
    if (rq.typed) begin
      if (rq.op != OpUnused) expected_cmds.push_back(rq.tcmd);
    end else begin
      foreach (run_cmds[i]) expected_cmds.push_back(run_cmds[i]);
    end
    @(negedge clk);
  endtask

  // Directed requests: cold cache, hits, extremes, resets and the unused code.
  request_t directed[] = '{
    '{OpLoad,   23'h000000, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpLoad,   23'h000000, 32'hffffffff, 32'hffffffff, 1'b1, TrigOnly},
    '{OpStore,  23'h000000, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpStore,  23'h000000, 32'hffffffff, 32'hffffffff, 1'b0, NoCmd},
    '{OpStore,  23'h7fffff, 32'h80000001, 32'h7ffffffe, 1'b0, NoCmd},
    '{OpLoad,   23'h7fffff, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpLoad,   23'h7fffff, 32'h12345678, 32'h00000000, 1'b1, TrigOnly},
    '{OpReset,  23'h7fffff, 32'hffffffff, 32'hffffffff, 1'b1, ButtonOnly},
    '{OpLoad,   23'h7fffff, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpUnused, 23'h000000, 32'h00000000, 32'h00000000, 1'b1, NoCmd},
    '{OpLoad,   23'h0003ff, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpLoad,   23'h000400, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpStore,  23'h2aaaaa, 32'ha5a5a5a5, 32'h5a5a5a5a, 1'b0, NoCmd},
    '{OpReset,  23'h000000, 32'h00000000, 32'h00000000, 1'b1, ButtonOnly},
    '{OpReset,  23'h2aaaaa, 32'h00000000, 32'h00000000, 1'b1, ButtonOnly},
    '{OpUnused, 23'h7fffff, 32'hffffffff, 32'hffffffff, 1'b1, NoCmd},
    '{OpLoad,   23'h555555, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpStore,  23'h555555, 32'h12345678, 32'h9abcdef0, 1'b0, NoCmd},
    '{OpStore,  23'h555555, 32'h00000001, 32'h80000000, 1'b0, NoCmd},
    '{OpLoad,   23'h555555, 32'h00000000, 32'h00000000, 1'b0, NoCmd},
    '{OpStore,  23'h000001, 32'hfffffffe, 32'h00000000, 1'b0, NoCmd},
    '{OpLoad,   23'h000000, 32'h00000000, 32'h00000000, 1'b0, NoCmd}
  };

  // Stimulus, drain and the final verdict.
  initial begin
    request_t    rq;
    int          counted;
    int          pick;
    logic [22:0] last_addr;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = OpStore;
    req_if.mem_address = '0;
    req_if.left_word   = '0;
    req_if.right_word  = '0;
    cmd_if.ready       = 1'b0;
    addr_cache         = '0;
    addr_cache_ok      = 1'b0;
    mismatches         = 0;
    no_gaps            = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) issue_request(directed[i]);

    // Random requests; addresses often repeat so that cache hits are common.
    counted   = 0;
    last_addr = '0;
    while (counted < RandomRequests) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) rq.op = OpStore;
      else if (pick < 16) rq.op = OpLoad;
      else if (pick < 18) rq.op = OpReset;
      else rq.op = OpUnused;
      pick = $urandom_range(0, 9);
      if (pick < 4) rq.addr = 23'($urandom);
      else if (pick < 7) rq.addr = last_addr;
      else if (pick < 8) rq.addr = 23'h7fffff;
      else if (pick < 9) rq.addr = '0;
      else rq.addr = 23'($urandom_range(0, 2047));
      rq.lw       = ($urandom_range(0, 7) == 0) ? 32'hffffffff : $urandom;
      rq.rw       = ($urandom_range(0, 7) == 0) ? 32'h00000000 : $urandom;
      rq.typed    = 1'b0;
      rq.tcmd     = NoCmd;
      last_addr   = rq.addr;
      // A stretch with no idling on either side.
      no_gaps     = (counted >= 60 && counted < 95);
      issue_request(rq);
      if (rq.op != OpUnused) counted++;
    end
    no_gaps      = 1'b0;
    req_if.valid = 1'b0;

    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS memory_access_command_serializer");
    end else begin
      $display("FAIL memory_access_command_serializer");
    end
    $finish;
  end

  // Command receiver: random stalls, then each transfer is checked in order.
  initial begin
    cmd_t got;
    cmd_t want;
    int   gap;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        cmd_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      cmd_if.ready = 1'b1;
      @(posedge clk);
      while (!cmd_if.valid) @(posedge clk);
      got = '{cmd_if.command_value, cmd_if.target_register, cmd_if.direct_command,
              cmd_if.last_of_run};
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected command: value %0d reg %0d direct %0b last %0b",
                   got.command_value, got.target_register, got.direct_command,
                   got.last_of_run);
      end else begin
        want = expected_cmds.pop_front();
        if (got.command_value !== want.command_value ||
            got.target_register !== want.target_register ||
            got.direct_command !== want.direct_command ||
            got.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("command mismatch: expected value %0d reg %0d direct %0b last %0b, %s",
                     want.command_value, want.target_register, want.direct_command,
                     want.last_of_run,
                     $sformatf("got value %0d reg %0d direct %0b last %0b",
                               got.command_value, got.target_register,
                               got.direct_command, got.last_of_run));
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IdleLimit) begin
        $display("FAIL memory_access_command_serializer");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/macs_pkg.sv
hw/rtl/macs_req_if.sv
hw/rtl/macs_cmd_if.sv
hw/rtl/memory_access_command_serializer.sv
test/tb_memory_access_command_serializer.sv
